// File: design/temperature_binned_calibration_store_core_macros.svh
// assertion macros shared by the checker of the calibration store core
// no dependencies; included by the checker file only
`ifndef TEMPERATURE_BINNED_CALIBRATION_STORE_CORE_MACROS_SVH
`define TEMPERATURE_BINNED_CALIBRATION_STORE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define TBCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbcs assertion failed");

// next-cycle implication, disabled while reset is applied
`define TBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbcs assertion failed");

`endif

// File: design/tbcs_pkg.sv
// shared types, codes and the record checksum of the calibration store
// no dependencies; imported by controller, datapath and top level
package tbcs_pkg;

    // request codes
    localparam logic REQ_STORE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_HSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_TX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_RTC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_TEMP    = 3'd4;
    localparam int CFG_DATA_W = 64;

    // output bucket field width
    localparam int BUCKET_W = 3;

    // checksum seed and weights
    localparam logic [31:0] CHECK_SEED = 32'h1F55_F1AA;
    localparam logic [31:0] W_TX       = 32'd7;
    localparam logic [31:0] W_RTC      = 32'd1319;
    localparam logic [31:0] W_TEMP     = 32'd12345;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic do_store;
        logic do_lookup;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
    } status_t;

    // wrapping checksum over one record, signed fields sign-extended
    function automatic logic [31:0] record_check(
        input logic [31:0]        hse,
        input logic [31:0]        tx,
        input logic signed [15:0] rtc,
        input logic signed [7:0]  tmp
    );
        logic [31:0] rtc_x;
        logic [31:0] tmp_x;
        rtc_x = {{16{rtc[15]}}, rtc};
        tmp_x = {{24{tmp[7]}}, tmp};
        return CHECK_SEED + hse + (tx * W_TX) + (rtc_x * W_RTC) + (tmp_x * W_TEMP);
    endfunction

endpackage

// File: design/tbcs_ctrl.sv
// request sequencer of the calibration store: handshakes and datapath commands
// depends on tbcs_pkg
module tbcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tbcs_pkg::status_t status,
    output tbcs_pkg::cmd_t    cmd
);
    import tbcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_lookup)
                begin
                    cmd.do_lookup = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    cmd.do_store = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/tbcs_datapath.sv
// calibration store datapath: config registers, bucket pick, record table,
// checksum and result registers; depends on tbcs_pkg
module tbcs_datapath #(
    parameter int NUM_BUCKETS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tbcs_pkg::cmd_t                    cmd,
    output tbcs_pkg::status_t                 status,
    input  logic                              cfg_write,
    input  logic [tbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              req_type,
    input  logic signed [7:0]                 temperature,
    input  logic [31:0]                       hse_freq,
    input  logic [31:0]                       tx_freq,
    input  logic signed [15:0]                rtc_corr,
    input  logic signed [7:0]                 rec_temp,
    output logic                              found,
    output logic [tbcs_pkg::BUCKET_W-1:0]     bucket,
    output logic [31:0]                       out_hse_freq,
    output logic [31:0]                       out_tx_freq,
    output logic signed [15:0]                out_rtc_corr,
    output logic signed [7:0]                 out_rec_temp
);
    import tbcs_pkg::*;

    localparam int BW = $clog2(NUM_BUCKETS);

    // configuration registers
    logic [CFG_DATA_W-1:0] bounds_reg;
    logic [31:0]           def_hse_reg;
    logic [31:0]           def_tx_reg;
    logic signed [15:0]    def_rtc_reg;
    logic signed [7:0]     def_temp_reg;

    // captured request
    logic                  req_type_reg;
    logic [BW-1:0]         bucket_reg;
    logic [31:0]           hse_reg;
    logic [31:0]           tx_reg;
    logic signed [15:0]    rtc_reg;
    logic signed [7:0]     temp_reg;

    // record table
    logic [31:0]           slot_hse_reg  [NUM_BUCKETS];
    logic [31:0]           slot_tx_reg   [NUM_BUCKETS];
    logic signed [15:0]    slot_rtc_reg  [NUM_BUCKETS];
    logic signed [7:0]     slot_temp_reg [NUM_BUCKETS];
    logic [31:0]           slot_check_reg[NUM_BUCKETS];

    // result registers
    logic                  found_reg;
    logic [31:0]           res_hse_reg;
    logic [31:0]           res_tx_reg;
    logic signed [15:0]    res_rtc_reg;
    logic signed [7:0]     res_temp_reg;

    logic [BW-1:0]         pick;
    logic                  stop;
    logic [31:0]           store_check;
    logic [31:0]           read_check;
    logic                  match;

    // config writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg   <= '0;
            def_hse_reg  <= '0;
            def_tx_reg   <= '0;
            def_rtc_reg  <= '0;
            def_temp_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BOUNDS:   bounds_reg   <= cfg_data;
                CFG_DEF_HSE:  def_hse_reg  <= cfg_data[31:0];
                CFG_DEF_TX:   def_tx_reg   <= cfg_data[31:0];
                CFG_DEF_RTC:  def_rtc_reg  <= cfg_data[15:0];
                CFG_DEF_TEMP: def_temp_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // bucket pick: advance while the next bound lies below the temperature
    always_comb
    begin
        pick = '0;
        stop = 1'b0;
        for (int i = 1; i < NUM_BUCKETS; i++)
        begin
            if (!stop && ($signed(bounds_reg[8*i +: 8]) < temperature))
            begin
                pick = BW'(i);
            end
            else
            begin
                stop = 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            bucket_reg   <= pick;
            hse_reg      <= hse_freq;
            tx_reg       <= tx_freq;
            rtc_reg      <= rtc_corr;
            temp_reg     <= rec_temp;
        end
    end

    assign status.is_lookup = (req_type_reg == REQ_LOOKUP);

    // checksums of the incoming and of the stored record
    assign store_check = record_check(hse_reg, tx_reg, rtc_reg, temp_reg);
    assign read_check  = record_check(slot_hse_reg[bucket_reg], slot_tx_reg[bucket_reg],
                                      slot_rtc_reg[bucket_reg], slot_temp_reg[bucket_reg]);
    assign match       = (read_check == slot_check_reg[bucket_reg]);

    // record table, zero after reset so no bucket passes its check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                slot_hse_reg[i]   <= '0;
                slot_tx_reg[i]    <= '0;
                slot_rtc_reg[i]   <= '0;
                slot_temp_reg[i]  <= '0;
                slot_check_reg[i] <= '0;
            end
        end
        else if (cmd.do_store)
        begin
            slot_hse_reg[bucket_reg]   <= hse_reg;
            slot_tx_reg[bucket_reg]    <= tx_reg;
            slot_rtc_reg[bucket_reg]   <= rtc_reg;
            slot_temp_reg[bucket_reg]  <= temp_reg;
            slot_check_reg[bucket_reg] <= store_check;
        end
    end

    // result: stored record on a good check, defaults otherwise
    always_ff @(posedge clk)
    begin
        if (cmd.do_lookup)
        begin
            found_reg <= match;
            if (match)
            begin
                res_hse_reg  <= slot_hse_reg[bucket_reg];
                res_tx_reg   <= slot_tx_reg[bucket_reg];
                res_rtc_reg  <= slot_rtc_reg[bucket_reg];
                res_temp_reg <= slot_temp_reg[bucket_reg];
            end
            else
            begin
                res_hse_reg  <= def_hse_reg;
                res_tx_reg   <= def_tx_reg;
                res_rtc_reg  <= def_rtc_reg;
                res_temp_reg <= def_temp_reg;
            end
        end
    end

    assign found        = found_reg;
    assign bucket       = BUCKET_W'(bucket_reg);
    assign out_hse_freq = res_hse_reg;
    assign out_tx_freq  = res_tx_reg;
    assign out_rtc_corr = res_rtc_reg;
    assign out_rec_temp = res_temp_reg;

endmodule

// File: design/temperature_binned_calibration_store_core.sv
// top level of the temperature binned calibration store
// depends on tbcs_pkg, tbcs_ctrl and tbcs_datapath
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready   | req_type, temperature, record fields
//   out     | output    | out_valid / out_ready | found, bucket, out_* record fields
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request at a time: a store beat passes capture and table write; a lookup beat passes
// capture, check and result load, and then the result beat, which waits on out_ready.
// in_ready is low from capture until the request is finished; cfg_ready is always high.
// reset clears the record table, so every bucket returns the defaults until stored.
module temperature_binned_calibration_store_core #(
    parameter int NUM_BUCKETS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic signed [7:0]                 temperature,
    input  logic [31:0]                       hse_freq,
    input  logic [31:0]                       tx_freq,
    input  logic signed [15:0]                rtc_corr,
    input  logic signed [7:0]                 rec_temp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [tbcs_pkg::BUCKET_W-1:0]     bucket,
    output logic [31:0]                       out_hse_freq,
    output logic [31:0]                       out_tx_freq,
    output logic signed [15:0]                out_rtc_corr,
    output logic signed [7:0]                 out_rec_temp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tbcs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    tbcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    tbcs_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .temperature  (temperature),
        .hse_freq     (hse_freq),
        .tx_freq      (tx_freq),
        .rtc_corr     (rtc_corr),
        .rec_temp     (rec_temp),
        .found        (found),
        .bucket       (bucket),
        .out_hse_freq (out_hse_freq),
        .out_tx_freq  (out_tx_freq),
        .out_rtc_corr (out_rtc_corr),
        .out_rec_temp (out_rec_temp)
    );

endmodule

// File: design/tbcs_checker.sv
// port-level checks of the calibration store core, bound to the top level
// depends on tbcs_pkg and the macros header
`include "temperature_binned_calibration_store_core_macros.svh"

module tbcs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              req_type,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              found,
    input logic [tbcs_pkg::BUCKET_W-1:0]     bucket,
    input logic [31:0]                       out_hse_freq,
    input logic [31:0]                       out_tx_freq
);
    import tbcs_pkg::*;

    // a stalled result beat holds
    `TBCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(bucket) && $stable(out_hse_freq) && $stable(out_tx_freq))

    // no new request while a result waits
    `TBCS_ASSERT_SAME(a_one_at_a_time, clk, rst_n, out_valid, !in_ready)

    // an accepted request closes the input side for the next cycle
    `TBCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)

    // a store request never produces a result
    `TBCS_ASSERT_NEXT(a_store_silent, clk, rst_n, $past(in_valid && in_ready && req_type == REQ_STORE), !out_valid)

    // exactly one result beat per lookup
    `TBCS_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid && out_ready, !out_valid)

endmodule

bind temperature_binned_calibration_store_core tbcs_checker u_tbcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .bucket       (bucket),
    .out_hse_freq (out_hse_freq),
    .out_tx_freq  (out_tx_freq)
);

// File: bench/tb_temperature_binned_calibration_store_core.sv
// self-checking testbench of the temperature binned calibration store core
// depends on tbcs_pkg and temperature_binned_calibration_store_core; keeps its own table model
module tb_temperature_binned_calibration_store_core;
    import tbcs_pkg::*;

    localparam int NUM_BUCKETS = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 155;
    localparam longint RUN_LIMIT = 4_000_000;

    // checksum seed and weights of a stored record
    localparam logic [31:0] SEAL_SEED   = 32'h1F55_F1AA;
    localparam logic [31:0] SEAL_W_TX   = 32'd7;
    localparam logic [31:0] SEAL_W_RTC  = 32'd1319;
    localparam logic [31:0] SEAL_W_TEMP = 32'd12345;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  temp;
        logic [31:0] hse;
        logic [31:0] tx;
        logic [15:0] rtc;
        logic [7:0]  rtemp;
    } cal_req_t;

    typedef struct packed {
        logic                found;
        logic [BUCKET_W-1:0] bucket;
        logic [31:0]         hse;
        logic [31:0]         tx;
        logic [15:0]         rtc;
        logic [7:0]          rtemp;
    } cal_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic signed [7:0]     temperature;
    logic [31:0]           hse_freq;
    logic [31:0]           tx_freq;
    logic signed [15:0]    rtc_corr;
    logic signed [7:0]     rec_temp;
    logic                  out_valid;
    logic                  out_ready;
    logic                  found;
    logic [BUCKET_W-1:0]   bucket;
    logic [31:0]           out_hse_freq;
    logic [31:0]           out_tx_freq;
    logic signed [15:0]    out_rtc_corr;
    logic signed [7:0]     out_rec_temp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model of the configuration and the record table
    logic [63:0] bounds_q;
    logic [31:0] def_hse;
    logic [31:0] def_tx;
    logic [15:0] def_rtc;
    logic [7:0]  def_rtemp;
    logic [31:0] tab_hse [NUM_BUCKETS];
    logic [31:0] tab_tx [NUM_BUCKETS];
    logic [15:0] tab_rtc [NUM_BUCKETS];
    logic [7:0]  tab_rtemp [NUM_BUCKETS];
    logic [31:0] tab_seal [NUM_BUCKETS];

    cal_res_t pending_lookups [$];

    // sender and receiver pacing
    logic     gappy;
    int       burst_left;
    rx_mode_t rx_mode;
    logic     hold_request;
    int       hold_left;
    logic [2:0] rx_phase;
    logic [7:0] rx_pattern;

    int mismatches;
    int n_stores;
    int n_lookups;
    int n_results;
    int n_writes;

    temperature_binned_calibration_store_core #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .temperature(temperature),
        .hse_freq(hse_freq),
        .tx_freq(tx_freq),
        .rtc_corr(rtc_corr),
        .rec_temp(rec_temp),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found(found),
        .bucket(bucket),
        .out_hse_freq(out_hse_freq),
        .out_tx_freq(out_tx_freq),
        .out_rtc_corr(out_rtc_corr),
        .out_rec_temp(out_rec_temp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("%0t: timeout with %0d lookups still pending", $time, pending_lookups.size());
        $display("Mismatches found");
        $finish;
    end

    // wrapping checksum of one record, signed fields sign-extended
    function automatic logic [31:0] seal_of(input logic [31:0] hse, input logic [31:0] tx,
                                            input logic [15:0] rtc, input logic [7:0] rtemp);
        logic [31:0] rtc_w;
        logic [31:0] tmp_w;
        rtc_w = {{16{rtc[15]}}, rtc};
        tmp_w = {{24{rtemp[7]}}, rtemp};
        return SEAL_SEED + hse + tx * SEAL_W_TX + rtc_w * SEAL_W_RTC + tmp_w * SEAL_W_TEMP;
    endfunction

    // advance while the next bound is strictly below the temperature
    function automatic int pick_bucket(input logic [7:0] temp);
        int b;
        b = 0;
        while (b < NUM_BUCKETS - 1 && $signed(bounds_q[8*(b+1) +: 8]) < $signed(temp))
            b++;
        return b;
    endfunction

    // store into the table model, or queue the lookup result it implies
    task automatic table_model_step(input cal_req_t r);
        int b;
        cal_res_t e;
        b = pick_bucket(r.temp);
        if (r.kind == REQ_STORE)
        begin
            tab_hse[b] = r.hse;
            tab_tx[b] = r.tx;
            tab_rtc[b] = r.rtc;
            tab_rtemp[b] = r.rtemp;
            tab_seal[b] = seal_of(r.hse, r.tx, r.rtc, r.rtemp);
            n_stores++;
        end
        else
        begin
            e.bucket = BUCKET_W'(b);
            if (seal_of(tab_hse[b], tab_tx[b], tab_rtc[b], tab_rtemp[b]) == tab_seal[b])
            begin
                e.found = 1'b1;
                e.hse = tab_hse[b];
                e.tx = tab_tx[b];
                e.rtc = tab_rtc[b];
                e.rtemp = tab_rtemp[b];
            end
            else
            begin
                e.found = 1'b0;
                e.hse = def_hse;
                e.tx = def_tx;
                e.rtc = def_rtc;
                e.rtemp = def_rtemp;
            end
            pending_lookups.push_back(e);
            n_lookups++;
        end
    endtask

    function automatic cal_req_t req_of(input logic kind, input logic [7:0] temp,
                                        input logic [31:0] hse, input logic [31:0] tx,
                                        input logic [15:0] rtc, input logic [7:0] rtemp);
        cal_req_t r;
        r.kind = kind;
        r.temp = temp;
        r.hse = hse;
        r.tx = tx;
        r.rtc = rtc;
        r.rtemp = rtemp;
        return r;
    endfunction

    // field value of the given width, biased towards zero, all ones and the signed limits
    function automatic logic [31:0] field_val(input int w);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = 32'(1) << (w - 1);
            3: v = (32'(1) << (w - 1)) - 32'd1;
            default: v = $urandom;
        endcase
        if (w < 32)
            v = v & ((32'(1) << w) - 32'd1);
        return v;
    endfunction

    // random request, a quarter of them at or next to a bound
    function automatic cal_req_t random_request(input int store_pct);
        cal_req_t r;
        int b;
        r.kind = ($urandom_range(0, 99) < store_pct) ? REQ_STORE : REQ_LOOKUP;
        if ($urandom_range(0, 3) == 0)
        begin
            b = $urandom_range(1, NUM_BUCKETS - 1);
            r.temp = bounds_q[8*b +: 8] + 8'($urandom_range(0, 2)) - 8'd1;
        end
        else
            r.temp = 8'(field_val(8));
        r.hse = field_val(32);
        r.tx = field_val(32);
        r.rtc = 16'(field_val(16));
        r.rtemp = 8'(field_val(8));
        return r;
    endfunction

    // random gap after a burst of beats
    task automatic sender_pause();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else if (gappy)
        begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(0, 7);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // offer one request beat and hold it until accepted
    task automatic send_request(input cal_req_t r);
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= r.kind;
        temperature <= r.temp;
        hse_freq <= r.hse;
        tx_freq <= r.tx;
        rtc_corr <= r.rtc;
        rec_temp <= r.rtemp;
        do
            @(posedge clk);
        while (!in_ready);
        table_model_step(r);
        sender_pause();
    endtask

    task automatic sender_stop();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // one register write beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BOUNDS:   bounds_q = val;
            CFG_DEF_HSE:  def_hse = val[31:0];
            CFG_DEF_TX:   def_tx = val[31:0];
            CFG_DEF_RTC:  def_rtc = val[15:0];
            CFG_DEF_TEMP: def_rtemp = val[7:0];
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for all results, then let a trailing store finish
    task automatic settle();
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: long hold-off on request, otherwise stalls by mode
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        rx_phase = '0;
        rx_pattern = 8'b1011_0010;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:    out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: out_ready <= rx_pattern[rx_phase];
                    default:    out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                rx_phase <= rx_phase + 3'd1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // compare each result beat with the oldest pending lookup
    always @(posedge clk)
    begin : result_check
        cal_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: result beat with no lookup pending, bucket %0d found %0b",
                         $time, bucket, found);
                mismatches++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                check_field("found", want.found, found);
                check_field("bucket", want.bucket, bucket);
                check_field("out_hse_freq", want.hse, out_hse_freq);
                check_field("out_tx_freq", want.tx, out_tx_freq);
                check_field("out_rtc_corr", want.rtc, out_rtc_corr[15:0]);
                check_field("out_rec_temp", want.rtemp, out_rec_temp[7:0]);
                n_results++;
            end
        end
    end

    // lookups in the first and the last bucket miss after reset and return the zero defaults
    task automatic test_reset_state();
        send_request(req_of(REQ_LOOKUP, 8'h80, '0, '0, '0, '0));
        send_request(req_of(REQ_LOOKUP, 8'hFF, '1, '1, '1, '1));
        send_request(req_of(REQ_LOOKUP, 8'h00, '0, '0, '0, '0));
        send_request(req_of(REQ_LOOKUP, 8'h01, '0, '0, '0, '0));
        send_request(req_of(REQ_LOOKUP, 8'h7F, '1, '1, '1, '1));
        sender_stop();
    endtask

    // bounds at the edges, field extremes, overwrite, zero record, ignored indexes
    task automatic test_directed();
        settle();
        write_reg(CFG_BOUNDS, 64'h643C_1400_F6CE_9C5A);
        write_reg(CFG_DEF_HSE, 64'hDEAD_BEEF_FFFF_FFFF);
        write_reg(CFG_DEF_TX, 64'h0);
        write_reg(CFG_DEF_RTC, 64'h8000);
        write_reg(CFG_DEF_TEMP, 64'h7F);
        send_request(req_of(REQ_LOOKUP, 8'(-128), '0, '0, '0, '0));
        send_request(req_of(REQ_STORE, 8'(-100), '1, '1, 16'h8000, 8'h80));
        send_request(req_of(REQ_LOOKUP, 8'(-128), '0, '0, '0, '0));
        send_request(req_of(REQ_STORE, 8'(-99), '0, '0, 16'h7FFF, 8'h7F));
        send_request(req_of(REQ_LOOKUP, 8'(-50), '0, '0, '0, '0));
        send_request(req_of(REQ_STORE, 8'd127, 32'h0123_4567, 32'h89AB_CDEF, 16'h5A5A, 8'hA5));
        send_request(req_of(REQ_LOOKUP, 8'd101, '0, '0, '0, '0));
        send_request(req_of(REQ_LOOKUP, 8'd100, '0, '0, '0, '0));
        // overwrite of one bucket
        send_request(req_of(REQ_STORE, 8'd0, 32'h1111_2222, 32'h3333_4444, 16'h1234, 8'h12));
        send_request(req_of(REQ_STORE, 8'(-5), 32'hCAFE_F00D, 32'h0BAD_C0DE, 16'hFEDC, 8'hF0));
        send_request(req_of(REQ_LOOKUP, 8'(-9), '0, '0, '0, '0));
        // an all-zero record still passes once stored
        send_request(req_of(REQ_STORE, 8'd10, '0, '0, '0, '0));
        send_request(req_of(REQ_LOOKUP, 8'd20, '1, '1, '1, '1));
        send_request(req_of(REQ_LOOKUP, 8'd50, '0, '0, '0, '0));
        sender_stop();

        // new defaults, writes past the last register, bounds out of order
        settle();
        write_reg(CFG_DEF_HSE, 64'h0);
        write_reg(CFG_DEF_TEMP + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_DEF_TX, 64'hFFFF_FFFF);
        write_reg(CFG_DEF_RTC, 64'h7FFF);
        write_reg(CFG_DEF_TEMP, 64'h80);
        write_reg(CFG_DEF_TEMP + 3'd3, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_BOUNDS, 64'h8080_8080_7F9C_3200);
        send_request(req_of(REQ_LOOKUP, 8'd50, '0, '0, '0, '0));
        send_request(req_of(REQ_LOOKUP, 8'd60, '0, '0, '0, '0));
        send_request(req_of(REQ_STORE, 8'd127, 32'h8000_0001, 32'h7FFF_FFFE, 16'h0001, 8'h01));
        send_request(req_of(REQ_LOOKUP, 8'd51, '0, '0, '0, '0));
        send_request(req_of(REQ_LOOKUP, 8'd10, '0, '0, '0, '0));
        sender_stop();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_back_pressure();
        settle();
        rx_mode = RX_OPEN;
        gappy = 1'b0;
        hold_request = 1'b1;
        for (int k = 0; k < 24; k++)
            send_request(random_request(20));
        sender_stop();
    endtask

    // fresh bounds and defaults per phase, including both extreme bound settings
    task automatic reconfigure(input int phase);
        logic [63:0] bnd;
        int acc;
        case (phase)
            0: bnd = {8{8'h80}};
            1: bnd = {8{8'h7F}};
            2, 4:
            begin
                bnd = {$urandom, $urandom};
                acc = -128 + $urandom_range(0, 30);
                for (int i = 1; i < NUM_BUCKETS; i++)
                begin
                    acc += $urandom_range(0, 40);
                    if (acc > 127)
                        acc = 127;
                    bnd[8*i +: 8] = acc[7:0];
                end
            end
            default: bnd = {$urandom, $urandom};
        endcase
        write_reg(CFG_BOUNDS, bnd);
        write_reg(CFG_DEF_HSE, {32'($urandom), field_val(32)});
        write_reg(CFG_DEF_TX, {32'($urandom), field_val(32)});
        write_reg(CFG_DEF_RTC, {48'($urandom), 16'(field_val(16))});
        write_reg(CFG_DEF_TEMP, {56'($urandom), 8'(field_val(8))});
        if (phase == 3)
            write_reg(CFG_DEF_TEMP + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    endtask

    // random mix of stores and lookups under random pacing
    task automatic test_random_phases();
        int store_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            reconfigure(phase);
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            store_pct = $urandom_range(25, 60);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 40 == 0)
                    gappy = ($urandom_range(0, 3) != 0);
                send_request(random_request(store_pct));
            end
            sender_stop();
        end
    endtask

    // reset, then the tests in turn
    initial
    begin
        in_valid = 1'b0;
        req_type = REQ_STORE;
        temperature = '0;
        hse_freq = '0;
        tx_freq = '0;
        rtc_corr = '0;
        rec_temp = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BOUNDS;
        cfg_data = '0;
        gappy = 1'b0;
        burst_left = 0;
        rx_mode = RX_OPEN;
        hold_request = 1'b0;
        mismatches = 0;
        n_stores = 0;
        n_lookups = 0;
        n_results = 0;
        n_writes = 0;
        bounds_q = '0;
        def_hse = '0;
        def_tx = '0;
        def_rtc = '0;
        def_rtemp = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            tab_hse[i] = '0;
            tab_tx[i] = '0;
            tab_rtc[i] = '0;
            tab_rtemp[i] = '0;
            tab_seal[i] = '0;
        end
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed();
        test_back_pressure();
        test_random_phases();
        settle();

        if (pending_lookups.size() != 0)
        begin
            $display("%0t: %0d lookups never answered", $time, pending_lookups.size());
            mismatches++;
        end
        $display("covered %0d stores and %0d lookups across %0d register writes",
                 n_stores, n_lookups, n_writes);
        $display("%0d results checked; bounds in order, out of order and at both extremes",
                 n_results);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/tbcs_pkg.sv
design/tbcs_ctrl.sv
design/tbcs_datapath.sv
design/temperature_binned_calibration_store_core.sv
design/tbcs_checker.sv
bench/tb_temperature_binned_calibration_store_core.sv
